// ----- rtl/ptm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ptm_pkg;

    // Field widths
    localparam int OPCODE_W = 1;
    localparam int CHAN_W   = 1;
    localparam int BYTES_W  = 16;
    localparam int TS_W     = 64;
    localparam int RATE_W   = 32;
    localparam int FRAMES_W = 32;
    localparam int FACTOR_W = 16;

    // Dividend of the rate divide: 32-bit byte count times 256000 (< 2^50)
    localparam int DVD_W    = 50;

    // Defaults
    localparam int                  NUM_CHANNELS_DEF = 2;
    localparam logic [FACTOR_W-1:0] SMOOTH_RESET     = 16'd58982;

    // Item opcodes
    localparam logic [OPCODE_W-1:0] OP_PACKET = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_POLL   = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/ptm_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ptm_in_if;
    logic                           valid;
    logic                           ready;
    logic [ptm_pkg::OPCODE_W-1:0]   opcode;
    logic [ptm_pkg::CHAN_W-1:0]     channel;
    logic [ptm_pkg::BYTES_W-1:0]    packet_bytes;
    logic [ptm_pkg::TS_W-1:0]       timestamp;

    modport source (output valid, opcode, channel, packet_bytes, timestamp, input ready);
    modport sink   (input valid, opcode, channel, packet_bytes, timestamp, output ready);
endinterface

`default_nettype wire

// ----- rtl/ptm_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ptm_out_if;
    logic                           valid;
    logic                           ready;
    logic [ptm_pkg::RATE_W-1:0]     smoothed_rate;
    logic [ptm_pkg::FRAMES_W-1:0]   frames_seen;
    logic [ptm_pkg::CHAN_W-1:0]     channel_echo;

    modport source (output valid, smoothed_rate, frames_seen, channel_echo, input ready);
    modport sink   (input valid, smoothed_rate, frames_seen, channel_echo, output ready);
endinterface

`default_nettype wire

// ----- rtl/ptm_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Radix-2 restoring divider, one quotient bit per cycle, saturating to 32 bits
module ptm_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [ptm_pkg::DVD_W-1:0]    i_dividend,
    input  wire logic [ptm_pkg::TS_W-1:0]     i_divisor,
    output logic                              o_done,
    output logic [ptm_pkg::RATE_W-1:0]        o_quotient
);
    import ptm_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [TS_W-1:0]  r_rem;
    logic [TS_W-1:0]  r_dvs;
    logic [DVD_W-1:0] r_quo;     // dividend shifts out the top, quotient in the bottom
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [TS_W:0]    w_trial;
    logic             w_ge;
    logic [TS_W:0]    w_diff;
    logic [TS_W-1:0]  n_rem;

    // One trial subtract per cycle
    always_comb begin
        w_trial = {r_rem, r_quo[DVD_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        w_diff  = w_trial - {1'b0, r_dvs};
        n_rem   = w_ge ? w_diff[TS_W-1:0] : w_trial[TS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = (|r_quo[DVD_W-1:RATE_W]) ? '1 : r_quo[RATE_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/ptm_smooth.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Exponential smoothing: (a*old + (1-a)*sample) in Q0.16, rounded half up.
// Computed as sample*2^16 + a*(old - sample), one factor bit per cycle, MSB first.
module ptm_smooth (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [ptm_pkg::FACTOR_W-1:0]  i_factor,
    input  wire logic [ptm_pkg::RATE_W-1:0]    i_old,
    input  wire logic [ptm_pkg::RATE_W-1:0]    i_sample,
    output logic                               o_done,
    output logic [ptm_pkg::RATE_W-1:0]         o_result
);
    import ptm_pkg::*;

    localparam int            PROD_W     = RATE_W + FACTOR_W + 2;
    localparam int            CNT_W      = $clog2(FACTOR_W + 1);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FACTOR_W - 1);

    logic signed [RATE_W:0]   r_diff;
    logic signed [PROD_W-1:0] r_prod;
    logic [FACTOR_W-1:0]      r_fac;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_busy;
    logic                     r_done;

    logic signed [PROD_W-1:0] w_addend;
    logic [PROD_W-1:0]        w_round;

    always_comb begin
        w_addend = r_fac[FACTOR_W-1]
                 ? {{(PROD_W-RATE_W-1){r_diff[RATE_W]}}, r_diff} : '0;
        w_round  = r_prod + ROUND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FACTOR_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift-add; the sample seed ends up scaled by 2^16 after all doublings
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_diff <= $signed({1'b0, i_old}) - $signed({1'b0, i_sample});
            r_prod <= PROD_W'(i_sample);
            r_fac  <= i_factor;
        end else if (r_busy) begin
            r_prod <= (r_prod <<< 1) + w_addend;
            r_fac  <= r_fac << 1;
        end
    end

    assign o_done   = r_done;
    assign o_result = w_round[FACTOR_W +: RATE_W];

endmodule

`default_nettype wire

// ----- rtl/packet_throughput_meter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake      Payload
// i_pkt     in   valid/ready    opcode, channel, packet_bytes, timestamp
// o_res     out  valid/ready    smoothed_rate, frames_seen, channel_echo
// i_cfg     in   write enable   smoothing_factor (i_cfg_data)
//
// One item at a time. A packet counts a frame, then either sets the time reference,
// saturates the rate on a zero interval, or runs the bit-serial divide to recompute it.
// A poll runs the 16-step serial smoothing multiply, then waits for the output register.
// Absent-channel packets are dropped; absent-channel polls go to the output with zeros.
// Synchronous active-low reset clears all meter state and loads the default factor.
// o_res stalls block input only while a poll result waits for a full output register.
module packet_throughput_meter #(
    parameter int NUM_CHANNELS = ptm_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    ptm_in_if.sink                             i_pkt,
    ptm_out_if.source                          o_res,
    input  wire logic                          i_cfg_we,
    input  wire logic [ptm_pkg::FACTOR_W-1:0]  i_cfg_data
);
    import ptm_pkg::*;

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PKT   = 3'd1;
    localparam logic [2:0] S_SCALE = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_POLL  = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    // Per-channel meter state
    logic [FRAMES_W-1:0] r_frames  [NUM_CHANNELS];
    logic [RATE_W-1:0]   r_acc     [NUM_CHANNELS];
    logic [TS_W-1:0]     r_tref    [NUM_CHANNELS];
    logic                r_refv    [NUM_CHANNELS];
    logic [RATE_W-1:0]   r_raw     [NUM_CHANNELS];
    logic                r_restart [NUM_CHANNELS];
    logic [RATE_W-1:0]   r_smooth  [NUM_CHANNELS];

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [FACTOR_W-1:0] r_factor;
    logic [CHAN_W-1:0]   r_ch;
    logic [BYTES_W-1:0]  r_bytes;
    logic [TS_W-1:0]     r_ts;
    logic [TS_W-1:0]     r_delta;
    logic [RATE_W-1:0]   r_hold_rate;
    logic [FRAMES_W-1:0] r_hold_frames;

    logic                r_out_valid;
    logic [RATE_W-1:0]   r_out_rate;
    logic [FRAMES_W-1:0] r_out_frames;
    logic [CHAN_W-1:0]   r_out_ch;

    logic                w_accept;
    logic                w_present;
    logic [CH_W-1:0]     w_idx;
    logic                w_restart;
    logic                w_ref_ok;
    logic [RATE_W-1:0]   w_acc_base;
    logic [RATE_W:0]     w_sum;
    logic [RATE_W-1:0]   w_acc_sat;
    logic [TS_W-1:0]     w_delta;
    logic [RATE_W+6:0]   w_prod125;
    logic [DVD_W-1:0]    w_dividend;
    logic                w_div_start;
    logic                w_div_done;
    logic [RATE_W-1:0]   w_quotient;
    logic                w_mul_start;
    logic                w_mul_done;
    logic [RATE_W-1:0]   w_sample;
    logic [RATE_W-1:0]   w_smoothed;
    logic                w_out_load;

    assign i_pkt.ready = (r_state == S_IDLE);
    assign w_accept    = i_pkt.valid && i_pkt.ready;
    assign w_present   = ({{(31){1'b0}}, i_pkt.channel} < 32'(NUM_CHANNELS));
    assign w_idx       = CH_W'(r_ch);

    // Packet update terms for the selected channel
    always_comb begin
        w_restart  = r_restart[w_idx];
        w_ref_ok   = !w_restart && r_refv[w_idx];
        w_acc_base = w_restart ? '0 : r_acc[w_idx];
        w_sum      = {1'b0, w_acc_base} + (RATE_W+1)'(r_bytes);
        w_acc_sat  = w_sum[RATE_W] ? '1 : w_sum[RATE_W-1:0];
        w_delta    = r_ts - r_tref[w_idx];
    end

    // bytes * 256000 = (bytes * 125) << 11, with 125 = 128 - 2 - 1
    always_comb begin
        w_prod125  = {r_acc[w_idx], 7'b0}
                   - (RATE_W+7)'({r_acc[w_idx], 1'b0})
                   - (RATE_W+7)'(r_acc[w_idx]);
        w_dividend = {w_prod125, 11'b0};
    end

    assign w_div_start = (r_state == S_SCALE) && (r_delta != '0);
    assign w_mul_start = (r_state == S_POLL);
    assign w_sample    = r_restart[w_idx] ? '0 : r_raw[w_idx];
    assign w_out_load  = (r_state == S_EMIT) && (!r_out_valid || o_res.ready);

    ptm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_delta),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    ptm_smooth u_smooth (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_mul_start),
        .i_factor (r_factor),
        .i_old    (r_smooth[w_idx]),
        .i_sample (w_sample),
        .o_done   (w_mul_done),
        .o_result (w_smoothed)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_pkt.opcode == OP_POLL) begin
                        n_state = w_present ? S_POLL : S_EMIT;
                    end else if (w_present) begin
                        n_state = S_PKT;
                    end
                end
            end
            S_PKT:   n_state = w_ref_ok ? S_SCALE : S_IDLE;
            S_SCALE: n_state = (r_delta != '0) ? S_DIV : S_IDLE;
            S_DIV:   if (w_div_done) n_state = S_IDLE;
            S_POLL:  n_state = S_MUL;
            S_MUL:   if (w_mul_done) n_state = S_EMIT;
            S_EMIT:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_factor <= SMOOTH_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_factor <= i_cfg_data;
            end
        end
    end

    // Item capture; an absent channel reports zeros
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch          <= i_pkt.channel;
            r_bytes       <= i_pkt.packet_bytes;
            r_ts          <= i_pkt.timestamp;
            r_hold_rate   <= '0;
            r_hold_frames <= '0;
        end else if ((r_state == S_MUL) && w_mul_done) begin
            r_hold_rate   <= w_smoothed;
            r_hold_frames <= r_frames[w_idx];
        end
        if (r_state == S_PKT) begin
            r_delta <= w_delta;
        end
    end

    // Meter state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_frames[i]  <= '0;
                r_acc[i]     <= '0;
                r_tref[i]    <= '0;
                r_refv[i]    <= 1'b0;
                r_raw[i]     <= '0;
                r_restart[i] <= 1'b0;
                r_smooth[i]  <= '0;
            end
        end else begin
            unique case (r_state)
                S_PKT: begin
                    r_frames[w_idx]  <= r_frames[w_idx] + FRAMES_W'(1);
                    r_restart[w_idx] <= 1'b0;
                    if (w_ref_ok) begin
                        r_acc[w_idx] <= w_acc_sat;
                    end else begin
                        r_acc[w_idx]  <= w_acc_base;
                        r_tref[w_idx] <= r_ts;
                        r_refv[w_idx] <= 1'b1;
                        if (w_restart) begin
                            r_raw[w_idx] <= '0;
                        end
                    end
                end
                S_SCALE: begin
                    // zero interval saturates the rate
                    if (r_delta == '0) begin
                        r_raw[w_idx] <= '1;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_raw[w_idx] <= w_quotient;
                    end
                end
                S_POLL: begin
                    r_restart[w_idx] <= 1'b1;
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        r_smooth[w_idx] <= w_smoothed;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_rate   <= r_hold_rate;
            r_out_frames <= r_hold_frames;
            r_out_ch     <= r_ch;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.smoothed_rate = r_out_rate;
    assign o_res.frames_seen   = r_out_frames;
    assign o_res.channel_echo  = r_out_ch;

`ifndef SYNTHESIS
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_MUL))
        else $error("smoother finished outside the multiply state");

    a_frame_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PKT) |=> (r_frames[w_idx] == $past(r_frames[w_idx]) + FRAMES_W'(1)))
        else $error("frame count did not advance on a packet");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_out_valid && (r_state == S_IDLE)))
        else $error("poll result not presented");
`endif

endmodule

`default_nettype wire

// ----- dv/ptm_checker.sv -----
`timescale 1ns / 1ps

// Watches the item and result channels of the throughput meter, keeps its own
// copy of both meters and compares every poll report as it is accepted.
module ptm_checker #(
    parameter int NUM_CHANNELS = ptm_pkg::NUM_CHANNELS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    ptm_in_if                                 i_pkt,
    ptm_out_if                                o_res,
    input  wire logic                         i_cfg_we,
    input  wire logic [ptm_pkg::FACTOR_W-1:0] i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);
    import ptm_pkg::*;

    // bytes per 1000 ticks in Q24.8
    localparam logic [63:0]       BYTES_TO_RATE = 64'd256000;
    localparam logic [RATE_W-1:0] RATE_MAX      = '1;
    localparam logic [31:0]       BYTES_MAX     = '1;

    typedef struct packed {
        logic [RATE_W-1:0]   rate;
        logic [FRAMES_W-1:0] frames;
        logic [CHAN_W-1:0]   chan;
    } t_report;

    // Per-channel meter state
    logic [FRAMES_W-1:0] frame_cnt     [NUM_CHANNELS];
    logic [31:0]         byte_sum      [NUM_CHANNELS];
    logic [TS_W-1:0]     t_ref         [NUM_CHANNELS];
    logic                ref_ok        [NUM_CHANNELS];
    logic [RATE_W-1:0]   rate_now      [NUM_CHANNELS];
    logic                restart_armed [NUM_CHANNELS];
    logic [RATE_W-1:0]   rate_avg      [NUM_CHANNELS];
    logic [FACTOR_W-1:0] weight_prev;

    t_report report_q[$];
    int      fails = 0;

    // Q24.8 rate over an elapsed span; zero span or overflow saturates
    function automatic logic [RATE_W-1:0] rate_of_span(logic [31:0] total,
                                                        logic [TS_W-1:0] span);
        logic [63:0] q;
        if (span == '0)
            return RATE_MAX;
        q = ({32'd0, total} * BYTES_TO_RATE) / span;
        return (q > {32'd0, RATE_MAX}) ? RATE_MAX : q[RATE_W-1:0];
    endfunction

    // Packet transfer: count it, restart if armed, then reference or accumulate
    function automatic void count_packet(int ch, logic [BYTES_W-1:0] nbytes,
                                         logic [TS_W-1:0] ts);
        logic [32:0] sum;
        frame_cnt[ch] = frame_cnt[ch] + 1'b1;
        if (restart_armed[ch]) begin
            byte_sum[ch]      = '0;
            ref_ok[ch]        = 1'b0;
            rate_now[ch]      = '0;
            restart_armed[ch] = 1'b0;
        end
        if (ref_ok[ch]) begin
            sum          = {1'b0, byte_sum[ch]} + {17'd0, nbytes};
            byte_sum[ch] = sum[32] ? BYTES_MAX : sum[31:0];
            rate_now[ch] = rate_of_span(byte_sum[ch], ts - t_ref[ch]);
        end else begin
            t_ref[ch]  = ts;
            ref_ok[ch] = 1'b1;
        end
    endfunction

    // Poll transfer: smooth with round half up, then arm a restart
    function automatic t_report poll_meter(int ch);
        logic [63:0] w, sample, acc;
        t_report     rep;
        rep.chan = ch[CHAN_W-1:0];
        if (ch >= NUM_CHANNELS) begin
            rep.rate   = '0;
            rep.frames = '0;
            return rep;
        end
        w      = {48'd0, weight_prev};
        sample = restart_armed[ch] ? 64'd0 : {32'd0, rate_now[ch]};
        acc    = w * {32'd0, rate_avg[ch]} + (64'd65536 - w) * sample + 64'd32768;
        restart_armed[ch] = 1'b1;
        rate_avg[ch]      = acc[47:16];
        rep.rate          = rate_avg[ch];
        rep.frames        = frame_cnt[ch];
        return rep;
    endfunction

    function automatic void check_field(string field, logic [CHAN_W-1:0] chan,
                                        logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: channel %0d %s expected %0d, got %0d",
                     $time, chan, field, want, got);
        end
    endfunction

    // Track config and transfers, compare results in order
    always @(posedge i_clk) begin
        t_report got, want;
        int      ch;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                frame_cnt[i]     = '0;
                byte_sum[i]      = '0;
                t_ref[i]         = '0;
                ref_ok[i]        = 1'b0;
                rate_now[i]      = '0;
                restart_armed[i] = 1'b0;
                rate_avg[i]      = '0;
            end
            weight_prev = SMOOTH_RESET;
            report_q.delete();
        end else begin
            // result side first: a poll taken on this edge cannot report on it
            if (o_res.valid && o_res.ready) begin
                got = {o_res.smoothed_rate, o_res.frames_seen, o_res.channel_echo};
                if (report_q.size() == 0) begin
                    fails++;
                    $display("%0t: result expected none, got channel %0d rate %0d frames %0d",
                             $time, got.chan, got.rate, got.frames);
                end else begin
                    want = report_q.pop_front();
                    check_field("smoothed_rate", want.chan, want.rate, got.rate);
                    check_field("frames_seen", want.chan, want.frames, got.frames);
                    check_field("channel_echo", want.chan, {31'd0, want.chan},
                                {31'd0, got.chan});
                end
            end
            if (i_cfg_we)
                weight_prev = i_cfg_data;
            if (i_pkt.valid && i_pkt.ready) begin
                ch = int'(i_pkt.channel);
                if (i_pkt.opcode == OP_POLL)
                    report_q.push_back(poll_meter(ch));
                else if (ch < NUM_CHANNELS)
                    count_packet(ch, i_pkt.packet_bytes, i_pkt.timestamp);
            end
        end
        o_pending    <= report_q.size();
        o_fail_count <= fails;
    end

endmodule

// ----- dv/tb_packet_throughput_meter.sv -----
`timescale 1ns / 1ps

module tb_packet_throughput_meter;
    import ptm_pkg::*;

    localparam int NUM_CH          = NUM_CHANNELS_DEF;
    localparam int RESET_CYCLES    = 12;
    localparam int DRAIN_CYCLES    = 64;    // lets the last packet's rate divide finish
    localparam int HOLD_CYCLES     = 400;
    localparam int STALL_LIMIT     = 4000;
    localparam int ITEMS_PER_PHASE = 260;
    localparam int BURST_ITEMS     = 24;
    localparam int POLL_PCT        = 15;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                cfg_we      = 1'b0;
    logic [FACTOR_W-1:0] cfg_data    = '0;
    logic                hold_req    = 1'b0;
    logic                hold_req_q  = 1'b0;
    int                  hold_left   = 0;
    int                  tx_idle_pct = 0;
    int                  rx_idle_pct = 0;
    int                  idle_cycles = 0;
    int                  fail_count;
    int                  pending;
    logic [TS_W-1:0]     t_now [NUM_CH];

    ptm_in_if  pkt_if ();
    ptm_out_if res_if ();

    packet_throughput_meter #(
        .NUM_CHANNELS (NUM_CH)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pkt      (pkt_if),
        .o_res      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    ptm_checker #(
        .NUM_CHANNELS (NUM_CH)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pkt        (pkt_if),
        .o_res        (res_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Result receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin
        hold_req_q <= hold_req;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            hold_left    <= 0;
        end else if (hold_req && !hold_req_q) begin
            res_if.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            res_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else begin
            res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Watchdog: too long without any transfer ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (pkt_if.valid && pkt_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL packet_throughput_meter");
            $finish;
        end
    end

    // Offer one item after a random gap; returns on the edge that takes it
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [CHAN_W-1:0] ch,
                             input logic [BYTES_W-1:0] nbytes, input logic [TS_W-1:0] ts);
        while ($urandom_range(99) < tx_idle_pct) begin
            pkt_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pkt_if.valid        <= 1'b1;
        pkt_if.opcode       <= op;
        pkt_if.channel      <= ch;
        pkt_if.packet_bytes <= nbytes;
        pkt_if.timestamp    <= ts;
        do @(posedge i_clk); while (!pkt_if.ready);
    endtask

    // Stop offering, let every report arrive and the last packet finish
    task automatic wait_idle();
        pkt_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_factor(input logic [FACTOR_W-1:0] f);
        cfg_we   <= 1'b1;
        cfg_data <= f;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    // Packet streams with steady arrival times, some polls, and a little noise
    task automatic run_traffic(input int n);
        logic [CHAN_W-1:0]   ch;
        logic [OPCODE_W-1:0] op;
        logic [BYTES_W-1:0]  nbytes;
        logic [TS_W-1:0]     ts;
        for (int k = 0; k < n; k++) begin
            ch = CHAN_W'($urandom_range(NUM_CH - 1));
            op = ($urandom_range(99) < POLL_PCT) ? OP_POLL : OP_PACKET;
            case ($urandom_range(9))
                0:       nbytes = '0;
                1:       nbytes = '1;
                2:       nbytes = BYTES_W'($urandom);
                default: nbytes = BYTES_W'($urandom_range(1500, 40));
            endcase
            case ($urandom_range(19))
                0:       ts = {$urandom, $urandom};
                1:       ts = t_now[ch] - TS_W'($urandom_range(100000, 1));
                2:       ts = t_now[ch] + {32'd0, $urandom};
                3, 4:    ts = t_now[ch];
                default: ts = t_now[ch] + TS_W'($urandom_range(5000, 1));
            endcase
            t_now[ch] = ts;
            send_item(op, ch, nbytes, ts);
        end
    endtask

    // Receiver holds off while polls keep coming, so the input backs up
    task automatic pressure_burst();
        hold_req <= 1'b1;
        for (int k = 0; k < BURST_ITEMS; k++)
            send_item((k % 3 == 0) ? OP_PACKET : OP_POLL, CHAN_W'(k % NUM_CH),
                      BYTES_W'(64 * k), t_now[k % NUM_CH] + TS_W'(1000 * k));
        hold_req <= 1'b0;
    endtask

    // Stimulus and verdict
    initial begin
        pkt_if.valid        = 1'b0;
        pkt_if.opcode       = OP_PACKET;
        pkt_if.channel      = '0;
        pkt_if.packet_bytes = '0;
        pkt_if.timestamp    = '0;
        foreach (t_now[c])
            t_now[c] = {$urandom, $urandom};
        tx_idle_pct = 21;
        rx_idle_pct = 67;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners at the reset smoothing factor
        send_item(OP_POLL,   1'b0, 16'd0,    64'd0);      // poll before any packet
        send_item(OP_PACKET, 1'b0, 16'd0,    64'd0);      // takes the time reference
        send_item(OP_PACKET, 1'b0, 16'hFFFF, 64'd0);      // zero interval saturates
        send_item(OP_POLL,   1'b0, 16'd0,    64'd0);
        send_item(OP_POLL,   1'b0, 16'hFFFF, '1);         // no interval since last poll
        send_item(OP_PACKET, 1'b1, 16'hFFFF, '1);         // reference at top of range
        send_item(OP_PACKET, 1'b1, 16'hFFFF, 64'd5);      // interval wraps through zero
        send_item(OP_PACKET, 1'b1, 16'd1,    64'h0000_0100_0000_0000);
        send_item(OP_POLL,   1'b1, 16'd0,    64'd0);
        send_item(OP_PACKET, 1'b0, 16'd1500, 64'd1000);   // restart, reference only
        send_item(OP_POLL,   1'b0, 16'd0,    64'd0);      // rate was cleared by restart
        send_item(OP_PACKET, 1'b0, 16'd1,    64'd1001);
        send_item(OP_PACKET, 1'b0, 16'd1,    64'd1002);   // one byte per tick
        send_item(OP_PACKET, 1'b0, 16'd100,  64'd1010);
        send_item(OP_PACKET, 1'b0, 16'd40,   64'd500);    // stamp goes backward
        send_item(OP_POLL,   1'b0, 16'd0,    64'd0);
        send_item(OP_PACKET, 1'b1, 16'd0,    64'hAAAA_5555_AAAA_5555);
        send_item(OP_PACKET, 1'b1, 16'd0,    64'hAAAA_5555_AAAA_5556);
        send_item(OP_PACKET, 1'b1, 16'h8000, 64'hAAAA_5555_AAAA_6000);
        send_item(OP_POLL,   1'b1, 16'd0,    64'd0);
        send_item(OP_POLL,   1'b1, 16'd0,    64'd0);
        wait_idle();

        // no weight on history
        write_factor('0);
        run_traffic(ITEMS_PER_PHASE);
        wait_idle();

        // nearly all weight on history, idling swapped
        write_factor('1);
        tx_idle_pct = 67;
        rx_idle_pct = 21;
        run_traffic(ITEMS_PER_PHASE);
        wait_idle();

        // random weight, back-pressure burst, then full rate
        write_factor(FACTOR_W'($urandom));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        pressure_burst();
        run_traffic(ITEMS_PER_PHASE);
        wait_idle();

        if (fail_count == 0 && pending == 0)
            $display("PASS packet_throughput_meter");
        else
            $display("FAIL packet_throughput_meter");
        $finish;
    end

endmodule
